// ===== hw/rtl/ftrm_pkg.sv =====
`default_nettype none

package ftrm_pkg;

  // Field and datapath widths
  localparam int SUM_W  = 28;
  localparam int LEN_W  = 24;
  localparam int CNT_W  = 4;
  localparam int RPM_W  = 15;
  localparam int DVD_W  = 28;
  localparam int DVS_W  = 33;
  localparam int REM_W  = DVS_W + 1;
  localparam int STEP_W = 5;

  // Last step index of one restoring division (one quotient bit per step)
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DVD_W - 1);

  localparam logic [CNT_W-1:0] MAX_SAMPLES      = 4'd10;
  localparam logic [DVD_W-1:0] TICKS_PER_MINUTE = 28'd60000000;
  localparam logic [RPM_W-1:0] RPM_MAX          = 15'd32767;

  // Configuration register indexes
  localparam logic [1:0] CFG_PPR     = 2'd0;
  localparam logic [1:0] CFG_SAMPLES = 2'd1;
  localparam logic [1:0] CFG_POLE    = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT = 2'd3;

  // Configuration reset values
  localparam logic [3:0]       PPR_RST     = 4'd2;
  localparam logic [3:0]       SAMPLES_RST = 4'd5;
  localparam logic [1:0]       POLE_RST    = 2'd1;
  localparam logic [LEN_W-1:0] TIMEOUT_RST = 24'd1000000;

  typedef struct packed {
    logic [3:0]       ppr;
    logic [3:0]       samples;
    logic [1:0]       pole;
    logic [LEN_W-1:0] timeout;
  } cfg_t;

  // End of a reading, handed from the pulse timer to the rate calculator
  typedef struct packed {
    logic             valid;
    logic             stall;
    logic [SUM_W-1:0] sum;
  } fin_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             valid;
    logic [RPM_W-1:0] rpm;
    logic             stalled;
  } res_t;

  // Clamp the sample count into 1..MAX_SAMPLES
  function automatic logic [CNT_W-1:0] eff_samples(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = CNT_W'(1);
    end else if (n > MAX_SAMPLES) begin
      r = MAX_SAMPLES;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ftrm_div.sv =====
`default_nettype none

module ftrm_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ftrm_pkg::div_req_t req,
  output ftrm_pkg::div_rsp_t      rsp
);
  import ftrm_pkg::*;

  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic              fits;

  // Shift in the next dividend bit and try the subtract
  assign rem_sh = {rem_r[REM_W-2:0], quo_r[DVD_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      if (step_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ftrm_pulse.sv =====
`default_nettype none

module ftrm_pulse (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           tick,
  input  wire logic           level,
  input  wire logic           start,
  input  wire ftrm_pkg::cfg_t cfg,
  output ftrm_pkg::fin_t      fin
);
  import ftrm_pkg::*;

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_WAIT_HIGH = 2'd1;
  localparam logic [1:0] PH_WAIT_LOW  = 2'd2;
  localparam logic [1:0] PH_MEASURE   = 2'd3;

  logic [1:0]       phase_r, phase_nxt;
  logic [LEN_W-1:0] wait_r, wait_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             first_r, first_nxt;

  logic [LEN_W-1:0] limit;
  logic [LEN_W-1:0] wait_inc;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] cnt_inc;
  logic             ended;
  logic [LEN_W-1:0] len;

  assign limit    = (cfg.timeout == '0) ? LEN_W'(1) : cfg.timeout;
  assign wait_inc = wait_r + LEN_W'(1);
  assign sum_add  = sum_r + SUM_W'(len);
  assign cnt_inc  = cnt_r + CNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    plen_nxt  = plen_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    ended     = 1'b0;
    len       = '0;
    fin       = '0;
    if (tick) begin
      // Advance the pulse phase on this sample
      case (phase_r)
        PH_IDLE: begin
          if (start) begin
            sum_nxt   = '0;
            cnt_nxt   = '0;
            first_nxt = 1'b1;
            phase_nxt = PH_WAIT_HIGH;
            wait_nxt  = '0;
            plen_nxt  = '0;
          end
        end
        PH_WAIT_HIGH: begin
          if (level) phase_nxt = PH_WAIT_LOW;
        end
        PH_WAIT_LOW: begin
          if (!level) begin
            phase_nxt = PH_MEASURE;
            plen_nxt  = LEN_W'(1);
          end
        end
        PH_MEASURE: begin
          if (level) begin
            ended = 1'b1;
            len   = plen_r;
          end else begin
            plen_nxt = plen_r + LEN_W'(1);
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase

      // Count toward the timeout; a timed-out pulse has length zero
      if (phase_r != PH_IDLE && !ended) begin
        wait_nxt = wait_inc;
        if (wait_inc >= limit) begin
          ended = 1'b1;
          len   = '0;
        end
      end

      // Close the pulse: qualify, accumulate or finish the reading
      if (ended) begin
        if (first_r) begin
          first_nxt = 1'b0;
          if (len == '0) begin
            phase_nxt = PH_IDLE;
            fin.valid = 1'b1;
            fin.stall = 1'b1;
          end else begin
            phase_nxt = PH_WAIT_HIGH;
            wait_nxt  = '0;
            plen_nxt  = '0;
          end
        end else begin
          sum_nxt = sum_add;
          cnt_nxt = cnt_inc;
          if (cnt_inc < eff_samples(cfg.samples)) begin
            phase_nxt = PH_WAIT_HIGH;
            wait_nxt  = '0;
            plen_nxt  = '0;
          end else begin
            phase_nxt = PH_IDLE;
            fin.valid = 1'b1;
            fin.stall = (sum_add == '0);
            fin.sum   = sum_add;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wait_r  <= '0;
      plen_r  <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
      first_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      plen_r  <= plen_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ftrm_calc.sv =====
`default_nettype none

module ftrm_calc (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ftrm_pkg::cfg_t     cfg,
  input  wire ftrm_pkg::fin_t     fin,
  input  wire ftrm_pkg::div_rsp_t div_rsp,
  input  wire logic               take,
  output ftrm_pkg::div_req_t      div_req,
  output ftrm_pkg::res_t          res,
  output logic                    idle
);
  import ftrm_pkg::*;

  localparam logic [2:0] C_IDLE     = 3'd0;
  localparam logic [2:0] C_DIV_AVG  = 3'd1;
  localparam logic [2:0] C_MUL      = 3'd2;
  localparam logic [2:0] C_DIV_RATE = 3'd3;
  localparam logic [2:0] C_DIV_POLE = 3'd4;
  localparam logic [2:0] C_HOLD     = 3'd5;

  logic [2:0]       st_r, st_nxt;
  logic [DVS_W-1:0] full_r, full_nxt;
  logic [RPM_W-1:0] rpm_r, rpm_nxt;
  logic             stl_r, stl_nxt;

  logic [3:0]       ppr_eff;
  logic [1:0]       pole_eff;
  logic [31:0]      product;
  logic [RPM_W-1:0] q_sat;

  assign ppr_eff  = (cfg.ppr == '0) ? 4'd1 : cfg.ppr;
  assign pole_eff = (cfg.pole == '0) ? 2'd1 : cfg.pole;
  // Average times pulses per rotation; the factor of two is a shift
  assign product  = 32'(div_rsp.quotient) * 32'(ppr_eff);
  assign q_sat    = (div_rsp.quotient > DVD_W'(RPM_MAX)) ? RPM_MAX
                                                         : div_rsp.quotient[RPM_W-1:0];

  always_comb begin
    st_nxt   = st_r;
    full_nxt = full_r;
    rpm_nxt  = rpm_r;
    stl_nxt  = stl_r;
    div_req  = '0;
    case (st_r)
      C_IDLE: begin
        if (fin.valid) begin
          if (fin.stall) begin
            rpm_nxt = '0;
            stl_nxt = 1'b1;
            st_nxt  = C_HOLD;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = fin.sum;
            div_req.divisor  = DVS_W'(eff_samples(cfg.samples));
            st_nxt           = C_DIV_AVG;
          end
        end
      end
      C_DIV_AVG: begin
        if (div_rsp.done) begin
          full_nxt = {product, 1'b0};
          st_nxt   = C_MUL;
        end
      end
      C_MUL: begin
        // Average below one tick saturates the speed
        if (full_r == '0) begin
          rpm_nxt = RPM_MAX;
          stl_nxt = 1'b0;
          st_nxt  = C_HOLD;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = TICKS_PER_MINUTE;
          div_req.divisor  = full_r;
          st_nxt           = C_DIV_RATE;
        end
      end
      C_DIV_RATE: begin
        if (div_rsp.done) begin
          if (pole_eff == 2'd1) begin
            rpm_nxt = q_sat;
            stl_nxt = 1'b0;
            st_nxt  = C_HOLD;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
            div_req.divisor  = DVS_W'(pole_eff);
            st_nxt           = C_DIV_POLE;
          end
        end
      end
      C_DIV_POLE: begin
        if (div_rsp.done) begin
          rpm_nxt = q_sat;
          stl_nxt = 1'b0;
          st_nxt  = C_HOLD;
        end
      end
      C_HOLD: begin
        if (take) st_nxt = C_IDLE;
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    full_r <= full_nxt;
    rpm_r  <= rpm_nxt;
    stl_r  <= stl_nxt;
  end

  assign res.valid   = (st_r == C_HOLD);
  assign res.rpm     = rpm_r;
  assign res.stalled = stl_r;
  assign idle        = (st_r == C_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/fan_tach_rpm_meter.sv =====
// Result: a stalled reading goes straight to the hold state; a full one runs 28-step
//   divisions on the shared divider, with a pole division only when the divisor exceeds 1.
// Throughput: one tick transaction per cycle while in_ready is high; input is held off
//   from the end of a reading until its result moves to the output register.
// Reset: synchronous active-low rst_n; config returns to ppr 2, samples 5, pole 1,
//   timeout 1000000 ticks, and the meter returns to idle with no result pending.
`default_nettype none

module fan_tach_rpm_meter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_tach_level,
  input  wire logic        in_start_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [14:0]      out_rpm,
  output logic             out_stalled,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);
  import ftrm_pkg::*;

  cfg_t             cfg_r;
  fin_t             fin;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  res_t             res;
  logic             calc_idle;
  logic             tick;
  logic             take;
  logic             out_valid_r, out_valid_nxt;
  logic [RPM_W-1:0] out_rpm_r;
  logic             out_stalled_r;

  assign in_ready = calc_idle;
  assign tick     = in_valid & in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ppr     <= PPR_RST;
      cfg_r.samples <= SAMPLES_RST;
      cfg_r.pole    <= POLE_RST;
      cfg_r.timeout <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PPR:     cfg_r.ppr     <= cfg_wdata[3:0];
        CFG_SAMPLES: cfg_r.samples <= cfg_wdata[3:0];
        CFG_POLE:    cfg_r.pole    <= cfg_wdata[1:0];
        CFG_TIMEOUT: cfg_r.timeout <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ftrm_pulse u_pulse (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (tick),
    .level (in_tach_level),
    .start (in_start_req),
    .cfg   (cfg_r),
    .fin   (fin)
  );

  ftrm_calc u_calc (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .fin     (fin),
    .div_rsp (div_rsp),
    .take    (take),
    .div_req (div_req),
    .res     (res),
    .idle    (calc_idle)
  );

  ftrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Move a finished result into the output register when it is empty or being read out
  assign take = res.valid & (~out_valid_r | out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (take) begin
      out_rpm_r     <= res.rpm;
      out_stalled_r <= res.stalled;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_rpm     = out_rpm_r;
  assign out_stalled = out_stalled_r;

`ifndef SYNTHESIS
  // A reading may only end while the calculator can take it
  a_fin_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fin.valid |-> calc_idle)
    else $error("reading ended while calculator busy");

  // The divider only answers while a conversion is in flight
  a_div_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> !calc_idle)
    else $error("divider result with calculator idle");

  // A stalled fan always reports zero speed
  a_stall_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stalled) |-> (out_rpm == '0))
    else $error("stalled result with nonzero rpm");

  // A result loaded into a full output register would drop the pending one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_rpm)))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/rpm_reading_checker.sv =====
`timescale 1ns / 100ps

module rpm_reading_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_tach_level,
  input  logic        in_start_req,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [14:0] out_rpm,
  input  logic        out_stalled,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output int          mismatches,
  output int          pending,
  output int          results_seen,
  output logic        meter_idle
);
  import ftrm_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_WAIT_HIGH, M_WAIT_LOW, M_COUNT} meter_state_t;

  // Register copies
  logic [3:0]       ppr_r;
  logic [3:0]       samples_r;
  logic [1:0]       pole_r;
  logic [LEN_W-1:0] timeout_r;

  // Pulse timer copy
  meter_state_t     state;
  logic [LEN_W-1:0] wait_cnt;
  logic [LEN_W-1:0] pulse_len;
  logic [SUM_W-1:0] len_sum;
  logic [CNT_W-1:0] samples_taken;
  logic             first_pulse;

  // Readings still owed by the block, oldest first
  logic [RPM_W-1:0] rpm_due[$];
  logic             stall_due[$];

  // Clamp the averaging count into 1..MAX_SAMPLES
  function automatic logic [CNT_W-1:0] samples_used();
    logic [CNT_W-1:0] n;
    n = samples_r;
    if (n == '0) begin
      n = CNT_W'(1);
    end else if (n > MAX_SAMPLES) begin
      n = MAX_SAMPLES;
    end
    return n;
  endfunction

  // Speed from the summed low time, saturated at full scale
  function automatic logic [RPM_W-1:0] rpm_from_sum(input logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] avg;
    logic [63:0]      full;
    logic [63:0]      q;
    logic [3:0]       ppr_eff;
    logic [1:0]       pole_eff;
    ppr_eff  = (ppr_r == '0) ? 4'd1 : ppr_r;
    pole_eff = (pole_r == '0) ? 2'd1 : pole_r;
    avg  = sum / samples_used();
    full = 64'(avg);
    full = full * ppr_eff * 2;
    if (full == 0) begin
      return RPM_MAX;
    end
    q = 64'(TICKS_PER_MINUTE);
    q = q / full;
    q = q / pole_eff;
    return (q > RPM_MAX) ? RPM_MAX : q[RPM_W-1:0];
  endfunction

  task automatic start_pulse();
    state     = M_WAIT_HIGH;
    wait_cnt  = '0;
    pulse_len = '0;
  endtask

  task automatic owe_reading(input logic [RPM_W-1:0] rpm, input logic stalled);
    rpm_due.push_back(rpm);
    stall_due.push_back(stalled);
  endtask

  // Advance the meter by one tick
  task automatic take_tick(input logic lvl, input logic st);
    logic             done;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] lim;
    done = 1'b0;
    len  = '0;
    lim  = timeout_r;
    if (lim == '0) begin
      lim = LEN_W'(1);
    end
    if (state == M_IDLE) begin
      // a start is only taken here; this tick does not sample the line
      if (st) begin
        len_sum       = '0;
        samples_taken = '0;
        first_pulse   = 1'b1;
        start_pulse();
      end
    end else begin
      case (state)
        M_WAIT_HIGH: begin
          if (lvl) state = M_WAIT_LOW;
        end
        M_WAIT_LOW: begin
          if (!lvl) begin
            state     = M_COUNT;
            pulse_len = LEN_W'(1);
          end
        end
        default: begin
          if (lvl) begin
            done = 1'b1;
            len  = pulse_len;
          end else begin
            pulse_len = pulse_len + 1'b1;
          end
        end
      endcase
      // timeout gives a zero-length pulse
      if (!done) begin
        wait_cnt = wait_cnt + 1'b1;
        if (wait_cnt >= lim) begin
          done = 1'b1;
          len  = '0;
        end
      end
      if (done) begin
        if (first_pulse) begin
          // the first pulse only proves the fan turns
          first_pulse = 1'b0;
          if (len == '0) begin
            state = M_IDLE;
            owe_reading({RPM_W{1'b0}}, 1'b1);
          end else begin
            start_pulse();
          end
        end else begin
          len_sum       = len_sum + SUM_W'(len);
          samples_taken = samples_taken + 1'b1;
          if (samples_taken < samples_used()) begin
            start_pulse();
          end else begin
            state = M_IDLE;
            if (len_sum == '0) begin
              owe_reading({RPM_W{1'b0}}, 1'b1);
            end else begin
              owe_reading(rpm_from_sum(len_sum), 1'b0);
            end
          end
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Track registers, step the meter, compare readings
  always @(posedge clk) begin
    logic [RPM_W-1:0] want_rpm;
    logic             want_stall;
    if (!rst_n) begin
      ppr_r         = PPR_RST;
      samples_r     = SAMPLES_RST;
      pole_r        = POLE_RST;
      timeout_r     = TIMEOUT_RST;
      state         = M_IDLE;
      wait_cnt      = '0;
      pulse_len     = '0;
      len_sum       = '0;
      samples_taken = '0;
      first_pulse   = 1'b0;
      rpm_due.delete();
      stall_due.delete();
      mismatches    = 0;
      results_seen  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PPR:     ppr_r     = cfg_wdata[3:0];
          CFG_SAMPLES: samples_r = cfg_wdata[3:0];
          CFG_POLE:    pole_r    = cfg_wdata[1:0];
          CFG_TIMEOUT: timeout_r = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        take_tick(in_tach_level, in_start_req);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (rpm_due.size() == 0) begin
          report_mismatch($sformatf("unexpected reading rpm=%0d stalled=%0b",
                                    out_rpm, out_stalled));
        end else begin
          want_rpm   = rpm_due.pop_front();
          want_stall = stall_due.pop_front();
          if (out_rpm !== want_rpm) begin
            report_mismatch($sformatf("rpm %0d, expected %0d", out_rpm, want_rpm));
          end
          if (out_stalled !== want_stall) begin
            report_mismatch($sformatf("stalled %0b, expected %0b", out_stalled, want_stall));
          end
        end
      end
    end
    pending    = rpm_due.size();
    meter_idle = (state == M_IDLE);
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ftrm_pkg::*;

  localparam int RESET_CYCLES    = 10;
  localparam int DRAIN_CYCLES    = 120;
  localparam int PRESSURE_CYCLES = 600;
  localparam int CYCLE_LIMIT     = 2000000;
  localparam int FIXED_PHASES    = 9;
  localparam int ITEM_GOAL       = 1800;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_tach_level;
  logic        in_start_req;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [14:0] out_rpm;
  logic        out_stalled;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_wdata;

  int   mismatches;
  int   pending;
  int   results_seen;
  logic meter_idle;

  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  int   items_sent   = 0;
  int   cycle_cnt    = 0;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  fan_tach_rpm_meter u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_tach_level (in_tach_level),
    .in_start_req  (in_start_req),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rpm       (out_rpm),
    .out_stalled   (out_stalled),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  rpm_reading_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_tach_level (in_tach_level),
    .in_start_req  (in_start_req),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rpm       (out_rpm),
    .out_stalled   (out_stalled),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .pending       (pending),
    .results_seen  (results_seen),
    .meter_idle    (meter_idle)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold once readings flow
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 8) begin
      out_ready <= 1'b0;
      hold_left <= PRESSURE_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Offer one tick transaction and hold it until taken
  task automatic send_item(input logic lvl, input logic st);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_tach_level <= lvl;
    in_start_req  <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Write all four registers, junk in the unused upper data bits
  task automatic load_config(input logic [3:0] ppr, input logic [3:0] ns,
                             input logic [1:0] pd, input logic [23:0] tmo);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PPR;
    cfg_wdata <= {20'($urandom()), ppr};
    @(posedge clk);
    cfg_index <= CFG_SAMPLES;
    cfg_wdata <= {20'($urandom()), ns};
    @(posedge clk);
    cfg_index <= CFG_POLE;
    cfg_wdata <= {22'($urandom()), pd};
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Finish any open reading with short pulses, then drain all readings
  task automatic settle();
    logic lvl;
    lvl = 1'b1;
    do begin
      send_item(lvl, 1'b0);
      lvl = !lvl;
    end while (!meter_idle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // cover the longest conversion so a stray reading still shows up
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Tach waveform of random high/low runs, frequent start requests, optional glitches
  task automatic run_traffic(input int max_run, input logic noisy);
    int   sent;
    int   got_base;
    int   run_len;
    logic lvl;
    sent     = 0;
    got_base = results_seen;
    lvl      = 1'b1;
    while ((sent < 120 || results_seen - got_base < 3) && sent < 3000) begin
      run_len = $urandom_range(1, max_run);
      repeat (run_len) begin
        if (noisy && $urandom_range(0, 7) == 0) begin
          send_item(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
        end else begin
          send_item(lvl, $urandom_range(0, 3) == 0);
        end
        sent++;
      end
      lvl = !lvl;
    end
  endtask

  initial begin
    logic [3:0]  ppr_v;
    logic [3:0]  ns_v;
    logic [1:0]  pd_v;
    logic [23:0] tmo_v;
    int          max_run;
    logic        noisy;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_tach_level = 1'b0;
    in_start_req  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_PPR;
    cfg_wdata     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n        <= 1'b1;
    snd_idle_pct = 26;
    rcv_idle_pct = 49;
    @(posedge clk);

    // Directed: short pulses, two samples, four-tick timeout
    load_config(4'd1, 4'd2, 2'd1, 24'd4);
    // one-tick pulses saturate the speed; a start while busy is dropped
    send_item(1'b1, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    // line stuck low: first pulse times out, fan stalled
    send_item(1'b0, 1'b1);
    repeat (4) send_item(1'b0, 1'b0);
    // one pulse plus one timeout: nonzero sum whose average floors to zero
    send_item(1'b1, 1'b1);
    repeat (2) begin
      send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b0);
      send_item(1'b1, 1'b0);
    end
    send_item(1'b1, 1'b0);
    repeat (3) send_item(1'b0, 1'b0);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < FIXED_PHASES || items_sent < ITEM_GOAL; ph++) begin
      noisy = 1'b1;
      case (ph)
        0: begin ppr_v = 4'd1;  ns_v = 4'd1;  pd_v = 2'd1; tmo_v = 24'hFFFFFF; max_run = 6;   end
        1: begin ppr_v = 4'd8;  ns_v = 4'd10; pd_v = 2'd2; tmo_v = 24'd1;      max_run = 4;   end
        2: begin ppr_v = 4'd0;  ns_v = 4'd0;  pd_v = 2'd0; tmo_v = 24'd0;      max_run = 3;   end
        3: begin ppr_v = 4'd15; ns_v = 4'd15; pd_v = 2'd3; tmo_v = 24'd20;     max_run = 10;  end
        4: begin ppr_v = 4'd3;  ns_v = 4'd4;  pd_v = 2'd2; tmo_v = 24'd6;      max_run = 8;   end
        5: begin
          // long clean pulses for low speeds
          ppr_v = 4'd15; ns_v = 4'd1; pd_v = 2'd3; tmo_v = 24'hFFFFFF; max_run = 60;
          noisy = 1'b0;
        end
        6: begin ppr_v = PPR_RST; ns_v = SAMPLES_RST; pd_v = POLE_RST; tmo_v = TIMEOUT_RST;
                 max_run = 12; end
        default: begin
          ppr_v   = 4'($urandom_range(0, 15));
          ns_v    = 4'($urandom_range(0, 15));
          pd_v    = 2'($urandom_range(0, 3));
          tmo_v   = 24'($urandom_range(0, 64));
          max_run = $urandom_range(1, 16);
        end
      endcase
      settle();
      if (ph < 2) begin
        snd_idle_pct = 26;
        rcv_idle_pct = 49;
      end else if (ph < 5) begin
        snd_idle_pct = 49;
        rcv_idle_pct = 26;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      load_config(ppr_v, ns_v, pd_v, tmo_v);
      run_traffic(max_run, noisy);
    end
    settle();

    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ftrm_pkg.sv
hw/rtl/ftrm_div.sv
hw/rtl/ftrm_pulse.sv
hw/rtl/ftrm_calc.sv
hw/rtl/fan_tach_rpm_meter.sv
tb/sv/rpm_reading_checker.sv
tb/sv/tb.sv
